@@ rtl/cqs_pkg.sv @@
// shared types and constants for the conformal quantile select block
package cqs_pkg;

    localparam int SCORE_W = 32;
    localparam int ALPHA_W = 16;

    // reset value of the miscoverage level, about 0.1 in Q0.16
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

    // 1.0 in Q0.16, one bit wider than alpha
    localparam logic [ALPHA_W:0] ONE_Q16 = 17'h10000;

    // rounding term that turns the shift by sixteen into a ceiling
    localparam logic [ALPHA_W-1:0] CEIL_ROUND = 16'hFFFF;

    // control word broadcast to every cell of the sorting chain
    typedef struct packed {
        logic               insert;
        logic               shift;
        logic [SCORE_W-1:0] score;
    } cell_ctrl_t;

endpackage

@@ rtl/cqs_cell.sv @@
// one cell of the sorted insertion chain
module cqs_cell
(
    input  logic                           clk,
    input  cqs_pkg::cell_ctrl_t            ctrl,
    input  logic                           occupied,
    input  logic                           prev_gt,
    input  logic [cqs_pkg::SCORE_W-1:0]    prev_value,
    input  logic [cqs_pkg::SCORE_W-1:0]    next_value,
    output logic [cqs_pkg::SCORE_W-1:0]    value,
    output logic                           gt
);

    logic [cqs_pkg::SCORE_W-1:0] value_reg;
    logic [cqs_pkg::SCORE_W-1:0] value_next;

    // an empty cell counts as larger than any score
    assign gt    = !occupied || (value_reg > ctrl.score);
    assign value = value_reg;

    // insert: keep, take the neighbor below, or take the new score
    // shift: move one place toward the head
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && gt)
        begin
            value_next = prev_gt ? prev_value : ctrl.score;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/conformal_quantile_select.sv @@
// top level of the conformal quantile select block
// Scores arrive one word per cycle while in_stall is low and are kept in ascending
// order in a chain of MAX_SCORES cells. On the last score the block inserts it,
// then does the rank multiply, then the rounding and clamp, then shifts the
// chain toward its head until the selected score sits in the first cell, and
// registers that score as the result word. Input is stalled from the last word
// until the result word is taken. Scores beyond MAX_SCORES in a batch are dropped
// and flagged in overflow.
// The miscoverage level register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block itself does not enforce.
module conformal_quantile_select
#(
    parameter int MAX_SCORES = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cqs_pkg::ALPHA_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cqs_pkg::SCORE_W-1:0]   score,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cqs_pkg::SCORE_W-1:0]   threshold,
    output logic                          overflow
);

    localparam int CNT_W  = $clog2(MAX_SCORES + 1);
    localparam int PROD_W = CNT_W + cqs_pkg::ALPHA_W + 2;
    localparam int RANK_W = PROD_W - cqs_pkg::ALPHA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RANK,
        S_SHIFT,
        S_OUT
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               count_reg;
    logic                           dropped_reg;
    logic [cqs_pkg::ALPHA_W-1:0]    alpha_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [CNT_W-1:0]               shift_cnt_reg;
    logic [cqs_pkg::SCORE_W-1:0]    threshold_reg;

    logic                           accept;
    logic                           full;
    cqs_pkg::cell_ctrl_t            ctrl;
    logic [cqs_pkg::SCORE_W-1:0]    cell_value [MAX_SCORES];
    logic                           cell_gt    [MAX_SCORES];

    logic [cqs_pkg::ALPHA_W:0]      one_minus_alpha;
    logic [CNT_W:0]                 n_plus_one;
    logic [PROD_W-1:0]              prod_next;
    logic [PROD_W-1:0]              rounded;
    logic [RANK_W-1:0]              rank_raw;
    logic [CNT_W-1:0]               rank_sel;

    // handshake
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign threshold = threshold_reg;
    assign overflow  = dropped_reg;
    assign full      = (count_reg == CNT_W'(MAX_SCORES));

    // chain control
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = (state_reg == S_SHIFT) && (shift_cnt_reg != '0);
    assign ctrl.score  = score;

    // sorted insertion chain
    for (genvar i = 0; i < MAX_SCORES; i++)
    begin : g_cell
        logic                        occ;
        logic                        prev_gt;
        logic [cqs_pkg::SCORE_W-1:0] prev_value;
        logic [cqs_pkg::SCORE_W-1:0] next_value;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
        end
        else
        begin : g_body
            assign prev_gt    = cell_gt[i-1];
            assign prev_value = cell_value[i-1];
        end

        if (i == MAX_SCORES - 1)
        begin : g_tail
            assign next_value = '0;
        end
        else
        begin : g_inner
            assign next_value = cell_value[i+1];
        end

        cqs_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
        );
    end

    // rank = ceil((n+1)*(1-alpha)), clamped to 1..n
    always_comb
    begin
        one_minus_alpha = cqs_pkg::ONE_Q16 - {1'b0, alpha_reg};
        n_plus_one      = {1'b0, count_reg} + (CNT_W+1)'(1);
        prod_next       = PROD_W'(n_plus_one) * PROD_W'(one_minus_alpha);
        rounded         = prod_reg + PROD_W'(cqs_pkg::CEIL_ROUND);
        rank_raw        = rounded[PROD_W-1:cqs_pkg::ALPHA_W];
        if (rank_raw == '0)
        begin
            rank_sel = CNT_W'(1);
        end
        else if (rank_raw > RANK_W'(count_reg))
        begin
            rank_sel = count_reg;
        end
        else
        begin
            rank_sel = rank_raw[CNT_W-1:0];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= cqs_pkg::ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            alpha_reg <= cfg_wdata;
        end
    end

    // control sequence and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            shift_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (last)
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_RANK;
                end
                S_RANK:
                begin
                    shift_cnt_reg <= rank_sel - CNT_W'(1);
                    state_reg     <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (shift_cnt_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        shift_cnt_reg <= shift_cnt_reg - CNT_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_next;
        end
        if ((state_reg == S_SHIFT) && (shift_cnt_reg == '0))
        begin
            threshold_reg <= cell_value[0];
        end
    end

endmodule

@@ rtl/cqs_checker.sv @@
// port checker for the conformal quantile select block
module cqs_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        last,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [cqs_pkg::SCORE_W-1:0] threshold,
    input logic                        overflow
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(threshold) && $stable(overflow))
        else $error("result word changed while stalled");

    // no new score is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // a score that is not last never produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last |=> !out_valid)
        else $error("result without last word");

    // one result per batch
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result repeated");

endmodule

bind conformal_quantile_select cqs_checker u_cqs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .threshold (threshold),
    .overflow  (overflow)
);
